// ===== hw/rtl/nssr_pkg.sv =====
package nssr_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int THR_W       = 16;
  localparam int COORD_W     = 16;
  localparam int SIZE_W      = 15;
  localparam int CTR_W       = COORD_W + 1;
  localparam int MAG_W       = 17;
  localparam int SQ_W        = 2 * MAG_W;
  localparam int SUM_W       = SQ_W + 1;
  localparam int ROOT_W      = 18;
  localparam int SQRT_STEPS  = 18;
  localparam int SQRT_W      = 2 * SQRT_STEPS;
  localparam int FLIGHT_W    = 6;

  localparam logic CFG_REGION_COUNT = 1'b0;
  localparam logic CFG_SNAP_LIMIT   = 1'b1;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic [IDX_W-1:0]           entry_index;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic [SIZE_W-1:0]          w;
    logic [SIZE_W-1:0]          h;
    logic                       eligible;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic [SIZE_W-1:0]          w;
    logic [SIZE_W-1:0]          h;
    logic                       eligible;
  } entry_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] best_index;
  } result_t;

  typedef struct packed {
    logic             valid;
    logic             elig;
    logic [IDX_W-1:0] idx;
  } tag_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } scan_state_t;

  // centre along one axis: edge plus half the extent
  function automatic logic signed [CTR_W-1:0] centre(
    input logic signed [COORD_W-1:0] p,
    input logic [SIZE_W-1:0]         s
  );
    logic signed [CTR_W-1:0] half;
    half = $signed({3'b000, s[SIZE_W-1:1]});
    return $signed({p[COORD_W-1], p}) + half;
  endfunction

  function automatic logic [MAG_W-1:0] abs_diff(
    input logic signed [CTR_W-1:0] a,
    input logic signed [CTR_W-1:0] b
  );
    logic signed [CTR_W:0] d;
    logic signed [CTR_W:0] m;
    d = $signed({a[CTR_W-1], a}) - $signed({b[CTR_W-1], b});
    m = d[CTR_W] ? -d : d;
    return m[MAG_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/nssr_front.sv =====
module nssr_front
  import nssr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  input  logic                      in_kind,
  input  logic [IDX_W-1:0]          in_entry_index,
  input  logic signed [COORD_W-1:0] in_rect_x,
  input  logic signed [COORD_W-1:0] in_rect_y,
  input  logic [SIZE_W-1:0]         in_rect_w,
  input  logic [SIZE_W-1:0]         in_rect_h,
  input  logic                      in_eligible,
  output logic                      in_full,
  output logic                      q_valid,
  output item_t                     q_item,
  input  logic                      q_pop
);

  item_t      fifo_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push;
  logic       do_pop;
  item_t      new_item;

  always_comb begin
    new_item.op          = op_t'(in_kind);
    new_item.entry_index = in_entry_index;
    new_item.x           = in_rect_x;
    new_item.y           = in_rect_y;
    new_item.w           = in_rect_w;
    new_item.h           = in_rect_h;
    new_item.eligible    = in_eligible;
  end

  assign in_full = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_item  = fifo_r[rd_ptr_r];
  assign do_push = in_push && !in_full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      fifo_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// ===== hw/rtl/nssr_sqrt.sv =====
module nssr_sqrt
  import nssr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  tag_t              in_tag,
  input  logic [SUM_W-1:0]  in_val,
  output tag_t              out_tag,
  output logic [ROOT_W-1:0] out_root
);

  logic [SQRT_W-1:0] n_r [SQRT_STEPS];
  logic [SQRT_W-1:0] r_r [SQRT_STEPS];
  tag_t              t_r [SQRT_STEPS];

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
    localparam logic [SQRT_W-1:0] BIT_V = SQRT_W'(1) << (2 * (SQRT_STEPS - 1 - g));
    logic [SQRT_W-1:0] n_in;
    logic [SQRT_W-1:0] r_in;
    tag_t              t_in;
    logic [SQRT_W-1:0] trial;

    if (g == 0) begin : g_first
      assign n_in = {{(SQRT_W-SUM_W){1'b0}}, in_val};
      assign r_in = '0;
      assign t_in = in_tag;
    end else begin : g_next
      assign n_in = n_r[g-1];
      assign r_in = r_r[g-1];
      assign t_in = t_r[g-1];
    end

    assign trial = r_in + BIT_V;

    // one root bit per stage
    always_ff @(posedge clk) begin
      if (n_in >= trial) begin
        n_r[g] <= n_in - trial;
        r_r[g] <= (r_in >> 1) + BIT_V;
      end else begin
        n_r[g] <= n_in;
        r_r[g] <= r_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        t_r[g] <= '0;
      end else begin
        t_r[g] <= t_in;
      end
    end
  end

  assign out_tag  = t_r[SQRT_STEPS-1];
  assign out_root = r_r[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

// ===== hw/rtl/nssr_back.sv =====
module nssr_back
  import nssr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  input  logic [CNT_W-1:0]  region_count,
  input  logic [THR_W-1:0]  snap_limit,
  input  logic              outq_full,
  output logic              res_push,
  output result_t           res
);

  scan_state_t state_r, state_nxt;

  entry_t table_mem [TABLE_DEPTH];
  entry_t rd_data_r;

  logic [CNT_W-1:0]        scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]        cnt_r;
  logic [CNT_W-1:0]        cnt_clamp;
  logic signed [CTR_W-1:0] wcx_r, wcy_r;
  logic                    mem_we;
  logic                    start;
  logic                    issue;

  tag_t              tag1_r, tag2_r, tag3_r, tag4_r;
  logic [MAG_W-1:0]  dx_r, dy_r;
  logic [SQ_W-1:0]   sqx_r, sqy_r;
  logic [SUM_W-1:0]  sum_r;
  tag_t              sq_tag;
  logic [ROOT_W-1:0] sq_root;

  logic [FLIGHT_W-1:0] inflight_r, inflight_nxt;
  logic                found_r;
  logic [IDX_W-1:0]    best_r;
  logic [ROOT_W-1:0]   best_dist_r;
  logic                take;

  assign cnt_clamp = (region_count > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                          : region_count;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid && q_item.op == OP_QUERY && !outq_full) begin
          state_nxt = (cnt_clamp == '0) ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx_r == cnt_r - 1'b1) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (inflight_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    mem_we   = 1'b0;
    start    = 1'b0;
    issue    = 1'b0;
    res_push = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid && q_item.op == OP_LOAD) begin
          q_pop  = 1'b1;
          mem_we = 1'b1;
        end else if (q_valid && !outq_full) begin
          q_pop = 1'b1;
          start = 1'b1;
        end
      end
      ST_SCAN:  issue = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  res_push = 1'b1;
      default:  ;
    endcase
  end

  assign scan_idx_nxt = start ? '0 : (issue ? scan_idx_r + 1'b1 : scan_idx_r);
  assign take         = sq_tag.valid && sq_tag.elig && (sq_root <= best_dist_r)
                        && (!found_r || sq_root < best_dist_r);
  assign inflight_nxt = inflight_r + FLIGHT_W'(issue) - FLIGHT_W'(sq_tag.valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_idx_r <= '0;
      inflight_r <= '0;
      found_r    <= 1'b0;
      tag1_r     <= '0;
      tag2_r     <= '0;
      tag3_r     <= '0;
      tag4_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      scan_idx_r <= scan_idx_nxt;
      inflight_r <= inflight_nxt;
      if (start) begin
        found_r <= 1'b0;
      end else if (take) begin
        found_r <= 1'b1;
      end
      tag1_r.valid <= issue;
      tag1_r.elig  <= 1'b0;
      tag1_r.idx   <= scan_idx_r[IDX_W-1:0];
      tag2_r       <= '{valid: tag1_r.valid, elig: rd_data_r.eligible, idx: tag1_r.idx};
      tag3_r       <= tag2_r;
      tag4_r       <= tag3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[q_item.entry_index] <= '{x: q_item.x, y: q_item.y, w: q_item.w,
                                        h: q_item.h, eligible: q_item.eligible};
    end
    rd_data_r <= table_mem[scan_idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r       <= cnt_clamp;
      wcx_r       <= centre(q_item.x, q_item.w);
      wcy_r       <= centre(q_item.y, q_item.h);
      best_r      <= '0;
      best_dist_r <= {{(ROOT_W-THR_W){1'b0}}, snap_limit};
    end else if (take) begin
      best_r      <= sq_tag.idx;
      best_dist_r <= sq_root;
    end
    dx_r  <= abs_diff(centre(rd_data_r.x, rd_data_r.w), wcx_r);
    dy_r  <= abs_diff(centre(rd_data_r.y, rd_data_r.h), wcy_r);
    sqx_r <= dx_r * dx_r;
    sqy_r <= dy_r * dy_r;
    sum_r <= {1'b0, sqx_r} + {1'b0, sqy_r};
  end

  nssr_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tag   (tag4_r),
    .in_val   (sum_r),
    .out_tag  (sq_tag),
    .out_root (sq_root)
  );

  assign res.found      = found_r;
  assign res.best_index = found_r ? best_r : '0;

  property p_push_has_room;
    @(posedge clk) disable iff (!rst_n) res_push |-> !outq_full;
  endproperty
  a_push_has_room: assert property (p_push_has_room)
    else $error("result pushed into a full queue");

  property p_no_result_in_flight;
    @(posedge clk) disable iff (!rst_n) res_push |-> (inflight_r == '0);
  endproperty
  a_no_result_in_flight: assert property (p_no_result_in_flight)
    else $error("result pushed while distances still in flight");

  property p_scan_in_range;
    @(posedge clk) disable iff (!rst_n) (state_r == ST_SCAN) |-> (scan_idx_r < cnt_r);
  endproperty
  a_scan_in_range: assert property (p_scan_in_range)
    else $error("scan index beyond count");

  property p_idle_empty;
    @(posedge clk) disable iff (!rst_n) (state_r == ST_IDLE) |-> (inflight_r == '0);
  endproperty
  a_idle_empty: assert property (p_idle_empty)
    else $error("pipeline busy while idle");

endmodule

// ===== hw/rtl/nearest_snap_region_search.sv =====
// Nearest snap region search: load items (kind 0) write one 64-entry table slot and give
// no result; query items (kind 1) give one result, the lowest-index eligible entry below
// region_count whose centre lies nearest the window centre, by floor square root of the
// squared distance, and only if that distance is at most the snap limit register. Items
// enter a two-deep request queue, so the input side keeps taking requests until that
// queue is full, while a query runs or a result waits. A query scans min(region_count,
// 64) entries: the table has one read port, so the scan reads one entry per cycle, and
// each read then passes a 22-stage distance and square-root pipeline that must drain
// before the result is queued. Results wait in a two-deep
// queue. The table is not cleared at reset; never query entries that were not loaded.
// Write configuration only while the block is idle.
module nearest_snap_region_search
  import nssr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic                      in_kind,
  input  logic [IDX_W-1:0]          in_entry_index,
  input  logic signed [COORD_W-1:0] in_rect_x,
  input  logic signed [COORD_W-1:0] in_rect_y,
  input  logic [SIZE_W-1:0]         in_rect_w,
  input  logic [SIZE_W-1:0]         in_rect_h,
  input  logic                      in_eligible,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic                      out_found,
  output logic [IDX_W-1:0]          out_best_index,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [THR_W-1:0]          cfg_wdata
);

  logic [CNT_W-1:0] region_count_r;
  logic [THR_W-1:0] snap_limit_r;

  logic    q_valid;
  item_t   q_item;
  logic    q_pop;
  logic    res_push;
  result_t res;

  result_t    outq_r [2];
  logic       out_wr_r, out_rd_r;
  logic [1:0] out_cnt_r, out_cnt_nxt;
  logic       outq_full;
  logic       do_out_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_count_r <= '0;
      snap_limit_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REGION_COUNT: region_count_r <= cfg_wdata[CNT_W-1:0];
        CFG_SNAP_LIMIT:   snap_limit_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  nssr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_kind        (in_kind),
    .in_entry_index (in_entry_index),
    .in_rect_x      (in_rect_x),
    .in_rect_y      (in_rect_y),
    .in_rect_w      (in_rect_w),
    .in_rect_h      (in_rect_h),
    .in_eligible    (in_eligible),
    .in_full        (in_full),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  nssr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .region_count   (region_count_r),
    .snap_limit     (snap_limit_r),
    .outq_full      (outq_full),
    .res_push       (res_push),
    .res            (res)
  );

  // result queue: hold finished results until popped
  assign outq_full  = (out_cnt_r == 2'd2);
  assign out_empty  = (out_cnt_r == 2'd0);
  assign do_out_pop = out_pop && !out_empty;
  assign out_cnt_nxt = out_cnt_r + {1'b0, res_push} - {1'b0, do_out_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_wr_r  <= 1'b0;
      out_rd_r  <= 1'b0;
      out_cnt_r <= 2'd0;
    end else begin
      out_cnt_r <= out_cnt_nxt;
      if (res_push) begin
        out_wr_r <= ~out_wr_r;
      end
      if (do_out_pop) begin
        out_rd_r <= ~out_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      outq_r[out_wr_r] <= res;
    end
  end

  assign out_found      = outq_r[out_rd_r].found;
  assign out_best_index = outq_r[out_rd_r].best_index;

endmodule

// ===== tb/tb_nearest_snap_region_search.sv =====
`timescale 1ns / 100ps

module tb_nearest_snap_region_search;
  import nssr_pkg::*;

  logic                      clk;
  logic                      rst_n;
  logic                      in_push;
  logic                      in_full;
  logic                      in_kind;
  logic [IDX_W-1:0]          in_entry_index;
  logic signed [COORD_W-1:0] in_rect_x;
  logic signed [COORD_W-1:0] in_rect_y;
  logic [SIZE_W-1:0]         in_rect_w;
  logic [SIZE_W-1:0]         in_rect_h;
  logic                      in_eligible;
  logic                      out_empty;
  logic                      out_pop;
  logic                      out_found;
  logic [IDX_W-1:0]          out_best_index;
  logic                      cfg_we;
  logic                      cfg_index;
  logic [THR_W-1:0]          cfg_wdata;

  nearest_snap_region_search DUT (.*);

  // Requests waiting to go in, and answers the block still owes us.
  item_t   request_backlog[$];
  result_t snap_answers[$];

  // Our own copy of the table and of both registers.
  entry_t      shadow_table[TABLE_DEPTH];
  int unsigned shadow_count;
  int unsigned shadow_threshold;

  int  errors;
  int  mismatches;
  int  answers_seen;
  bit  calm;         // set for the final stretch: no idling on either side
  int  send_gap;
  int  take_gap;
  int  hold_off;
  bit  hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Floor square root, one result bit per step from the top.
  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  // Apply one request to the shadow table; queue the answer a query owes.
  function automatic void predict_snap(input item_t it);
    int              wcx, wcy, ecx, ecy, dx, dy;
    longint unsigned d, best_d;
    bit              hit;
    int unsigned     best, lim;
    result_t         res;
    if (it.op == OP_LOAD) begin
      shadow_table[it.entry_index] = '{x: it.x, y: it.y, w: it.w, h: it.h,
                                       eligible: it.eligible};
      return;
    end
    wcx = int'(it.x) + int'(it.w >> 1);
    wcy = int'(it.y) + int'(it.h >> 1);
    lim = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : shadow_count;
    hit = 1'b0;
    best = 0;
    best_d = shadow_threshold;
    for (int unsigned i = 0; i < lim; i++) begin
      if (!shadow_table[i].eligible) continue;
      ecx = int'(shadow_table[i].x) + int'(shadow_table[i].w >> 1);
      ecy = int'(shadow_table[i].y) + int'(shadow_table[i].h >> 1);
      dx = ecx - wcx;
      dy = ecy - wcy;
      d = floor_root(longint'(dx) * longint'(dx) + longint'(dy) * longint'(dy));
      // strict less keeps the lowest index on a tie
      if (d <= best_d && (!hit || d < best_d)) begin
        hit = 1'b1;
        best = i;
        best_d = d;
      end
    end
    res.found = hit;
    res.best_index = hit ? best[IDX_W-1:0] : '0;
    snap_answers.push_back(res);
  endfunction

  // Driver: present the oldest pending request, with random bursts of idle cycles.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        predict_snap(request_backlog.pop_front());
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_push <= 1'b0;
      end else if (!calm && request_backlog.size() > 0 && $urandom_range(0, 14) == 0) begin
        send_gap <= $urandom_range(0, 14);
        in_push <= 1'b0;
      end else if (request_backlog.size() > 0) begin
        in_push        <= 1'b1;
        in_kind        <= request_backlog[0].op;
        in_entry_index <= request_backlog[0].entry_index;
        in_rect_x      <= request_backlog[0].x;
        in_rect_y      <= request_backlog[0].y;
        in_rect_w      <= request_backlog[0].w;
        in_rect_h      <= request_backlog[0].h;
        in_eligible    <= request_backlog[0].eligible;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Monitor: check each popped answer against the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        answers_seen <= answers_seen + 1;
        if (snap_answers.size() == 0) begin
          errors++;
          if (mismatches < 10)
            $display("unexpected answer found=%0b best_index=%0d", out_found, out_best_index);
          mismatches++;
        end else begin
          want = snap_answers.pop_front();
          if (want.found !== out_found || want.best_index !== out_best_index) begin
            errors++;
            if (mismatches < 10)
              $display("answer %0d: expected found=%0b best_index=%0d, got found=%0b best_index=%0d",
                       answers_seen, want.found, want.best_index, out_found, out_best_index);
            mismatches++;
          end
        end
      end
      // Once, hold off long enough that both internal queues fill and the
      // input side stalls while the driver keeps offering.
      if (!hold_done && answers_seen == 30) begin
        hold_done <= 1'b1;
        hold_off  <= 600;
        out_pop   <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_pop  <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap <= take_gap - 1;
        out_pop  <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        take_gap <= $urandom_range(0, 14);
        out_pop  <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic idx, input int unsigned value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[THR_W-1:0];
    if (idx == CFG_REGION_COUNT) shadow_count = value & 32'h7F;
    else shadow_threshold = value & 32'hFFFF;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_request(input op_t op, input int idx, input int x, input int y,
                             input int w, input int h, input bit elig);
    item_t it;
    it.op = op;
    it.entry_index = idx[IDX_W-1:0];
    it.x = x[COORD_W-1:0];
    it.y = y[COORD_W-1:0];
    it.w = w[SIZE_W-1:0];
    it.h = h[SIZE_W-1:0];
    it.eligible = elig;
    request_backlog.push_back(it);
  endtask

  // Mostly clustered coordinates so that snaps actually happen; some full range.
  function automatic int pick_coord();
    if ($urandom_range(0, 9) < 6) return $urandom_range(0, 600) - 300;
    return $urandom_range(0, 65535) - 32768;
  endfunction

  function automatic int pick_size();
    if ($urandom_range(0, 9) < 6) return $urandom_range(0, 600);
    return $urandom_range(0, 32767);
  endfunction

  task automatic add_random(input int n);
    for (int k = 0; k < n; k++)
      add_request($urandom_range(0, 99) < 35 ? OP_LOAD : OP_QUERY, $urandom_range(0, 63),
                  pick_coord(), pick_coord(), pick_size(), pick_size(), $urandom_range(0, 1));
  endtask

  // Hold until every request is in and every answer out, then let the back end settle.
  task automatic drain();
    wait (request_backlog.size() == 0 && snap_answers.size() == 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic phase(input int unsigned cnt, input int unsigned thr, input int n);
    write_reg(CFG_REGION_COUNT, cnt);
    write_reg(CFG_SNAP_LIMIT, thr);
    add_random(n);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_kind = 1'b0;
    in_entry_index = '0;
    in_rect_x = '0;
    in_rect_y = '0;
    in_rect_w = '0;
    in_rect_h = '0;
    in_eligible = 1'b0;
    out_pop = 1'b0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_wdata = '0;
    errors = 0;
    mismatches = 0;
    answers_seen = 0;
    calm = 1'b0;
    send_gap = 0;
    take_gap = 0;
    hold_off = 0;
    hold_done = 1'b0;
    shadow_count = 0;
    shadow_threshold = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: count 0, so this query must miss even before any load.
    add_request(OP_QUERY, 0, 0, 0, 0, 0, 1'b0);
    // Fill every slot so that no later query touches an unwritten entry.
    for (int i = 0; i < TABLE_DEPTH; i++)
      add_request(OP_LOAD, i, pick_coord(), pick_coord(), pick_size(), pick_size(),
                  $urandom_range(0, 1));
    drain();

    // Directed: extremes, ties, ignored fields, ineligible entries.
    write_reg(CFG_REGION_COUNT, 64);
    write_reg(CFG_SNAP_LIMIT, 65535);
    add_request(OP_LOAD, 5, 1000, 1000, 20, 20, 1'b1);
    add_request(OP_LOAD, 9, 1000, 1000, 21, 21, 1'b1);     // same centre as slot 5
    add_request(OP_QUERY, 0, 1010, 1010, 0, 0, 1'b0);       // tie: slot 5 wins
    add_request(OP_QUERY, 63, 1000, 1000, 20, 20, 1'b1);   // query ignores index, flag
    add_request(OP_LOAD, 5, 1000, 1000, 20, 20, 1'b0);     // drop slot 5 from the race
    add_request(OP_QUERY, 17, 1010, 1010, 1, 1, 1'b1);
    add_request(OP_LOAD, 63, 32767, -32768, 32767, 0, 1'b1);
    add_request(OP_LOAD, 0, -32768, 32767, 0, 32767, 1'b1);
    add_request(OP_QUERY, 0, -32768, 32767, 0, 32767, 1'b0);
    add_request(OP_QUERY, 0, 32767, -32768, 32767, 0, 1'b0);
    add_request(OP_QUERY, 0, 32767, 32767, 32767, 32767, 1'b1);
    add_request(OP_QUERY, 0, -32768, -32768, 0, 0, 1'b0);
    add_request(OP_QUERY, 0, -21846, 21845, 21845, 10922, 1'b1);
    drain();
    write_reg(CFG_SNAP_LIMIT, 0);
    add_request(OP_QUERY, 0, -32768, 32767, 1, 32767, 1'b0);  // exact hit at threshold 0
    add_request(OP_QUERY, 0, -32767, 32767, 0, 32767, 1'b0);  // one off: miss
    drain();

    phase(64, 65535, 150);
    phase(0, 65535, 40);
    phase(1, 0, 60);
    phase(64, 0, 80);
    phase(37, 300, 150);
    phase(64, 2000, 180);
    phase(20, 80, 100);
    calm <= 1'b1;
    phase(64, 150, 120);

    if (errors == 0) begin
      $display("PASS nearest_snap_region_search");
    end else begin
      $display("FAIL nearest_snap_region_search");
    end
    $finish;
  end

  initial begin
    #(10 * 2_000_000);
    $display("FAIL nearest_snap_region_search");
    $finish;
  end

endmodule
